/* rtl/tcon_pkg.sv */
// ----------------------------------------------------------------------------
// tcon_pkg
// Shared constants, item types and controller/datapath handshake structs for
// the text console engine.
// ----------------------------------------------------------------------------
package tcon_pkg;

    // Screen geometry
    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;

    // Field widths
    localparam int OP_W   = 2;
    localparam int CHAR_W = 8;
    localparam int TGT_W  = 8;
    localparam int ADDR_W = 11;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int CELL_W = 16;
    localparam int ATTR_W = 8;

    // Character codes
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;

    // Attribute after reset: white on black
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd15;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_MOVE  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_READ  = 2'd3;

    // Command item
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] char_code;
        logic [TGT_W-1:0]  target_row;
        logic [TGT_W-1:0]  target_col;
        logic [ADDR_W-1:0] cell_index;
    } t_cmd_item;

    // Response item
    typedef struct packed {
        logic [ADDR_W-1:0] hw_cursor_location;
        logic [ROW_W-1:0]  cur_row;
        logic [COL_W-1:0]  cur_col;
        logic [CELL_W-1:0] cell_data;
    } t_rsp_item;

    // Controller to datapath commands
    typedef struct packed {
        logic latch_cmd;   // capture the accepted transaction
        logic exec_put;    // write char at cursor, advance cursor
        logic exec_move;   // range-checked cursor move
        logic exec_home;   // cursor to origin
        logic rd_cell;     // issue buffer read at requested index
        logic cnt_clr;     // reset sweep counter
        logic fill_zero;   // write zero at counter, advance
        logic fill_blank;  // write blank at counter, advance
        logic scroll_step; // one pipelined copy step of the scroll
        logic load_out;    // load response register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            need_scroll;
        logic            copy_end;
        logic            last_cell;
        logic            out_free;
    } t_dp_sts;

    // Linear cell address of a cursor position
    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
    endfunction

endpackage

/* rtl/tcon_cmd_if.sv */
// ----------------------------------------------------------------------------
// tcon_cmd_if
// Command channel: valid/ready plus one console operation.
// ----------------------------------------------------------------------------
interface tcon_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [tcon_pkg::OP_W-1:0]   op;
    logic [tcon_pkg::CHAR_W-1:0] char_code;
    logic [tcon_pkg::TGT_W-1:0]  target_row;
    logic [tcon_pkg::TGT_W-1:0]  target_col;
    logic [tcon_pkg::ADDR_W-1:0] cell_index;

    modport source (output valid, op, char_code, target_row, target_col, cell_index,
                    input ready);
    modport sink (input valid, op, char_code, target_row, target_col, cell_index,
                  output ready);
endinterface

/* rtl/tcon_rsp_if.sv */
// ----------------------------------------------------------------------------
// tcon_rsp_if
// Response channel: valid/ready plus cursor state and read-back cell word.
// ----------------------------------------------------------------------------
interface tcon_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [tcon_pkg::ADDR_W-1:0] hw_cursor_location;
    logic [tcon_pkg::ROW_W-1:0]  cur_row;
    logic [tcon_pkg::COL_W-1:0]  cur_col;
    logic [tcon_pkg::CELL_W-1:0] cell_data;

    modport source (output valid, hw_cursor_location, cur_row, cur_col, cell_data,
                    input ready);
    modport sink (input valid, hw_cursor_location, cur_row, cur_col, cell_data,
                  output ready);
endinterface

/* rtl/tcon_cfg_if.sv */
// ----------------------------------------------------------------------------
// tcon_cfg_if
// Configuration write channel for the text attribute register.
// ----------------------------------------------------------------------------
interface tcon_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [tcon_pkg::ATTR_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

/* rtl/tcon_dp.sv */
// ----------------------------------------------------------------------------
// tcon_dp
// Datapath: cell buffer memory, cursor and synced location registers,
// attribute register, sweep counter and response register.
// ----------------------------------------------------------------------------
module tcon_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  tcon_pkg::t_dp_cmd     i_cmd,
    output tcon_pkg::t_dp_sts     o_sts,
    input  tcon_pkg::t_cmd_item   i_item,
    input  logic                  i_cfg_valid,
    input  logic [tcon_pkg::ATTR_W-1:0] i_cfg_data,
    output logic                  o_rsp_valid,
    output tcon_pkg::t_rsp_item   o_rsp_item,
    input  logic                  i_rsp_ready
);
    import tcon_pkg::*;

    // Cell buffer
    logic [CELL_W-1:0] r_mem [CELL_COUNT];
    logic [CELL_W-1:0] r_rd;
    logic              r_rd_ok;

    // Latched transaction
    t_cmd_item r_item;

    // Architectural state
    logic [ROW_W-1:0]  r_row;
    logic [COL_W-1:0]  r_col;
    logic [ADDR_W-1:0] r_hw;
    logic [ATTR_W-1:0] r_attr;
    logic [ADDR_W-1:0] r_cnt;

    // Response register
    logic      r_out_valid;
    t_rsp_item r_out;

    // Put: cursor advance
    logic              is_newline;
    logic [COL_W:0]    col_inc;
    logic              col_wrap;
    logic              row_step;
    logic [ROW_W:0]    row_inc;
    logic              row_over;
    logic [ADDR_W-1:0] cur_addr;

    assign is_newline = (r_item.char_code == NEWLINE_CODE);
    assign col_inc    = {1'b0, r_col} + 1'b1;
    assign col_wrap   = (col_inc >= (COL_W+1)'(COLUMNS));
    assign row_step   = is_newline || col_wrap;
    assign row_inc    = {1'b0, r_row} + 1'b1;
    assign row_over   = row_step && (row_inc >= (ROW_W+1)'(ROWS));
    assign cur_addr   = cell_addr(r_row, r_col);

    // Move range check
    logic move_ok;
    assign move_ok = (r_item.target_row < TGT_W'(ROWS)) &&
                     (r_item.target_col < TGT_W'(COLUMNS));

    // Read index range check
    logic cidx_ok;
    assign cidx_ok = (r_item.cell_index < ADDR_W'(CELL_COUNT));

    // Sweep counter compares
    logic cnt_copy_end;
    assign cnt_copy_end = (r_cnt == ADDR_W'(COPY_COUNT));

    // Memory port selection
    logic              mem_we;
    logic [ADDR_W-1:0] mem_wa;
    logic [CELL_W-1:0] mem_wd;
    logic              mem_re;
    logic [ADDR_W-1:0] mem_ra;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_cnt;
        mem_wd = '0;
        priority if (i_cmd.fill_zero) begin
            mem_we = 1'b1;
        end else if (i_cmd.fill_blank) begin
            mem_we = 1'b1;
            mem_wd = {r_attr, SPACE_CODE};
        end else if (i_cmd.scroll_step) begin
            // write side trails the read side by one cell
            mem_we = (r_cnt != '0);
            mem_wa = r_cnt - 1'b1;
            mem_wd = r_rd;
        end else if (i_cmd.exec_put) begin
            mem_we = !is_newline;
            mem_wa = cur_addr;
            mem_wd = {r_attr, r_item.char_code};
        end
    end

    always_comb begin
        mem_re = 1'b0;
        mem_ra = r_item.cell_index;
        if (i_cmd.scroll_step) begin
            mem_re = !cnt_copy_end;
            mem_ra = r_cnt + ADDR_W'(COLUMNS);
        end else if (i_cmd.rd_cell) begin
            mem_re = cidx_ok;
        end
    end

    // Memory array
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_ra];
        end
    end

    // Transaction capture and read-valid flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_cmd) begin
            r_item <= i_item;
        end
        if (i_cmd.rd_cell) begin
            r_rd_ok <= cidx_ok;
        end
    end

    // Synced location as of this transaction
    logic              do_sync;
    logic [ADDR_W-1:0] n_hw;
    assign do_sync = (r_item.op == OP_PUT) || (r_item.op == OP_CLEAR);
    assign n_hw    = do_sync ? cur_addr : r_hw;

    // Control and architectural registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row       <= '0;
            r_col       <= '0;
            r_hw        <= '0;
            r_attr      <= ATTR_RESET;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_attr <= i_cfg_data;
            end

            // cursor
            if (i_cmd.exec_put) begin
                r_col <= row_step ? '0 : col_inc[COL_W-1:0];
                if (row_over) begin
                    r_row <= ROW_W'(ROWS - 1);
                end else if (row_step) begin
                    r_row <= row_inc[ROW_W-1:0];
                end
            end else if (i_cmd.exec_move && move_ok) begin
                r_row <= r_item.target_row[ROW_W-1:0];
                r_col <= r_item.target_col[COL_W-1:0];
            end else if (i_cmd.exec_home) begin
                r_row <= '0;
                r_col <= '0;
            end

            // sweep counter
            if (i_cmd.cnt_clr) begin
                r_cnt <= '0;
            end else if (i_cmd.fill_zero || i_cmd.fill_blank) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_cmd.scroll_step && !cnt_copy_end) begin
                r_cnt <= r_cnt + 1'b1;
            end

            // response valid
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
                r_hw        <= n_hw;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Response payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out.hw_cursor_location <= n_hw;
            r_out.cur_row            <= r_row;
            r_out.cur_col            <= r_col;
            r_out.cell_data          <= ((r_item.op == OP_READ) && r_rd_ok) ? r_rd : '0;
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp_item  = r_out;

    // Status back to controller
    assign o_sts.op          = r_item.op;
    assign o_sts.need_scroll = row_over;
    assign o_sts.copy_end    = cnt_copy_end;
    assign o_sts.last_cell   = (r_cnt == ADDR_W'(CELL_COUNT - 1));
    assign o_sts.out_free    = !r_out_valid || i_rsp_ready;

endmodule

/* rtl/tcon_ctrl.sv */
// ----------------------------------------------------------------------------
// tcon_ctrl
// Controller: sequences reset clearing, operation dispatch, scroll copy,
// blank fill and response hand-off.
// ----------------------------------------------------------------------------
module tcon_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    output logic              o_cmd_ready,
    output tcon_pkg::t_dp_cmd o_cmd,
    input  tcon_pkg::t_dp_sts i_sts
);
    import tcon_pkg::*;

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_EXEC   = 3'd2;
    localparam logic [2:0] S_SCROLL = 3'd3;
    localparam logic [2:0] S_BLANK  = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Next state and command decode
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd_ready = 1'b0;
        unique case (r_state)
            S_INIT: begin
                o_cmd.fill_zero = 1'b1;
                if (i_sts.last_cell) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    o_cmd.latch_cmd = 1'b1;
                    n_state         = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_sts.op)
                    OP_PUT: begin
                        o_cmd.exec_put = 1'b1;
                        if (i_sts.need_scroll) begin
                            o_cmd.cnt_clr = 1'b1;
                            n_state       = S_SCROLL;
                        end else begin
                            n_state = S_DONE;
                        end
                    end
                    OP_MOVE: begin
                        o_cmd.exec_move = 1'b1;
                        n_state         = S_DONE;
                    end
                    OP_CLEAR: begin
                        o_cmd.exec_home = 1'b1;
                        o_cmd.cnt_clr   = 1'b1;
                        n_state         = S_BLANK;
                    end
                    OP_READ: begin
                        o_cmd.rd_cell = 1'b1;
                        n_state       = S_DONE;
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_SCROLL: begin
                // counter parks at the copy end; blank fill continues from there
                o_cmd.scroll_step = 1'b1;
                if (i_sts.copy_end) begin
                    n_state = S_BLANK;
                end
            end
            S_BLANK: begin
                o_cmd.fill_blank = 1'b1;
                if (i_sts.last_cell) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* rtl/text_console_cursor_scroll.sv */
// Put, move and read run latch, execute and respond states; ready rises with the response.
// Transactions do not overlap: the next is accepted only once the last response is loaded.
// A put that scrolls adds 1921 pipelined copy steps and 80 blank writes.
// Clear adds 2000 blank cell writes, one blank cell write per cycle.
// Reset: synchronous; a clearing pass zeroes all 2000 cells of the buffer before ready rises.
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Text-mode console engine: 80x25 attribute:character cell buffer with a
// logical cursor, wrapping, scrolling, clear and synced hardware cursor.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tcon_cmd_if.sink   i_cmd,
    tcon_rsp_if.source o_rsp,
    tcon_cfg_if.sink   i_cfg
);
    import tcon_pkg::*;

    t_dp_cmd   w_dp_cmd;
    t_dp_sts   w_dp_sts;
    t_cmd_item w_item;
    t_rsp_item w_rsp_item;
    logic      w_cmd_ready;
    logic      w_rsp_valid;

    // Command payload
    assign w_item.op         = i_cmd.op;
    assign w_item.char_code  = i_cmd.char_code;
    assign w_item.target_row = i_cmd.target_row;
    assign w_item.target_col = i_cmd.target_col;
    assign w_item.cell_index = i_cmd.cell_index;
    assign i_cmd.ready       = w_cmd_ready;

    // Configuration is always taken
    assign i_cfg.ready = 1'b1;

    // Response channel
    assign o_rsp.valid              = w_rsp_valid;
    assign o_rsp.hw_cursor_location = w_rsp_item.hw_cursor_location;
    assign o_rsp.cur_row            = w_rsp_item.cur_row;
    assign o_rsp.cur_col            = w_rsp_item.cur_col;
    assign o_rsp.cell_data          = w_rsp_item.cell_data;

    tcon_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .o_cmd_ready (w_cmd_ready),
        .o_cmd       (w_dp_cmd),
        .i_sts       (w_dp_sts)
    );

    tcon_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_dp_cmd),
        .o_sts       (w_dp_sts),
        .i_item      (w_item),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .o_rsp_valid (w_rsp_valid),
        .o_rsp_item  (w_rsp_item),
        .i_rsp_ready (o_rsp.ready)
    );

endmodule

/* tb/text_console_cursor_scroll_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_tb
// Self-checking bench for the text console engine. A mirror of the cell
// buffer, cursor and synced hardware cursor predicts every response. Each
// response is checked field by field against the oldest prediction. The run
// covers directed corner cases and one long response stall, then long random
// traffic, with random idling on both channels in all but the last phase.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll_tb;
    import tcon_pkg::*;

    logic i_clk;
    logic i_rst_n;

    tcon_cmd_if cmd_if ();
    tcon_rsp_if rsp_if ();
    tcon_cfg_if cfg_if ();

    text_console_cursor_scroll dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_rsp   (rsp_if),
        .i_cfg   (cfg_if)
    );

    // Mirror of the console state
    logic [CELL_W-1:0] screen_mirror [CELL_COUNT];
    int unsigned       mirror_row;
    int unsigned       mirror_col;
    int unsigned       mirror_hw_loc;
    logic [ATTR_W-1:0] mirror_attr;

    t_rsp_item pending_rsp_q [$];
    int        mismatch_count;
    int        idle_pct;
    int        rsp_hold_cycles;

    // Clock
    always #1 i_clk = ~i_clk;

    // Run limit
    initial begin
        #50_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Apply one console operation to the mirror, return the response it causes
    function automatic t_rsp_item console_apply(input t_cmd_item c);
        t_rsp_item         r;
        logic [CELL_W-1:0] blank;
        logic [CELL_W-1:0] data;
        data  = '0;
        blank = {mirror_attr, SPACE_CODE};
        case (c.op)
            OP_PUT: begin
                if (c.char_code == NEWLINE_CODE) begin
                    mirror_row++;
                    mirror_col = 0;
                end else begin
                    screen_mirror[mirror_row * COLUMNS + mirror_col] = {mirror_attr, c.char_code};
                    mirror_col++;
                    if (mirror_col >= COLUMNS) begin
                        mirror_col = 0;
                        mirror_row++;
                    end
                end
                // past the last row: scroll up, blank bottom line
                if (mirror_row >= ROWS) begin
                    for (int i = 0; i < COPY_COUNT; i++)
                        screen_mirror[i] = screen_mirror[i + COLUMNS];
                    for (int i = COPY_COUNT; i < CELL_COUNT; i++)
                        screen_mirror[i] = blank;
                    mirror_row = ROWS - 1;
                end
                mirror_hw_loc = mirror_row * COLUMNS + mirror_col;
            end
            OP_MOVE: begin
                // out-of-range requests are dropped; no cursor sync
                if (c.target_row < ROWS && c.target_col < COLUMNS) begin
                    mirror_row = 32'(c.target_row);
                    mirror_col = 32'(c.target_col);
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < CELL_COUNT; i++)
                    screen_mirror[i] = blank;
                mirror_row    = 0;
                mirror_col    = 0;
                mirror_hw_loc = 0;
            end
            default: begin
                if (c.cell_index < CELL_COUNT)
                    data = screen_mirror[c.cell_index];
            end
        endcase
        r.hw_cursor_location = ADDR_W'(mirror_hw_loc);
        r.cur_row            = ROW_W'(mirror_row);
        r.cur_col            = COL_W'(mirror_col);
        r.cell_data          = data;
        return r;
    endfunction

    function automatic t_cmd_item mk_cmd(input logic [OP_W-1:0] op,
                                         input logic [CHAR_W-1:0] ch,
                                         input logic [TGT_W-1:0] row,
                                         input logic [TGT_W-1:0] col,
                                         input logic [ADDR_W-1:0] idx);
        t_cmd_item c;
        c.op         = op;
        c.char_code  = ch;
        c.target_row = row;
        c.target_col = col;
        c.cell_index = idx;
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Command and config drivers (called at a falling edge, return at one)
    // ------------------------------------------------------------------

    task automatic send_cmd(input t_cmd_item c);
        while ($urandom_range(99) < idle_pct) begin
            cmd_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        cmd_if.valid      <= 1'b1;
        cmd_if.op         <= c.op;
        cmd_if.char_code  <= c.char_code;
        cmd_if.target_row <= c.target_row;
        cmd_if.target_col <= c.target_col;
        cmd_if.cell_index <= c.cell_index;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        pending_rsp_q.push_back(console_apply(c));
        @(negedge i_clk);
    endtask

    // Drop valid and wait for every outstanding transaction to return
    task automatic drain_console();
        cmd_if.valid <= 1'b0;
        while (pending_rsp_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_attr(input logic [ATTR_W-1:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        mirror_attr = value;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Response side: random ready, optional long hold, checker
    // ------------------------------------------------------------------

    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rsp_hold_cycles > 0) begin
                rsp_if.ready <= 1'b0;
                rsp_hold_cycles--;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("ERROR @%0t %s: expected %0d, got %0d", $time, what, want, got);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_rsp_item want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (pending_rsp_q.size() == 0) begin
                report_mismatch("response with none pending", 0, 1);
            end else begin
                want = pending_rsp_q.pop_front();
                if (rsp_if.hw_cursor_location != want.hw_cursor_location)
                    report_mismatch("hw_cursor_location", 32'(want.hw_cursor_location),
                                    32'(rsp_if.hw_cursor_location));
                if (rsp_if.cur_row != want.cur_row)
                    report_mismatch("cur_row", 32'(want.cur_row), 32'(rsp_if.cur_row));
                if (rsp_if.cur_col != want.cur_col)
                    report_mismatch("cur_col", 32'(want.cur_col), 32'(rsp_if.cur_col));
                if (rsp_if.cell_data != want.cell_data)
                    report_mismatch("cell_data", 32'(want.cell_data), 32'(rsp_if.cell_data));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Buffer reads zero after reset; out-of-range index reads zero
    task automatic test_reset_state();
        send_cmd(mk_cmd(OP_READ, 8'h00, 8'h00, 8'h00, 11'd0));
        send_cmd(mk_cmd(OP_READ, 8'hFF, 8'hFF, 8'hFF, 11'(CELL_COUNT - 1)));
        send_cmd(mk_cmd(OP_READ, 8'h00, 8'h00, 8'h00, 11'h7FF));
        drain_console();
    endtask

    // Character extremes and a newline mid-screen
    task automatic test_put_chars();
        send_cmd(mk_cmd(OP_PUT, 8'h00, 8'h00, 8'h00, 11'h000));
        send_cmd(mk_cmd(OP_PUT, 8'hFF, 8'hFF, 8'hFF, 11'h7FF));
        send_cmd(mk_cmd(OP_PUT, 8'h80, 8'h00, 8'h00, 11'h000));
        send_cmd(mk_cmd(OP_PUT, NEWLINE_CODE, 8'h00, 8'h00, 11'h000));
        drain_console();
    endtask

    // In-range corners, out-of-range rows and columns; moves never sync
    task automatic test_cursor_moves();
        send_cmd(mk_cmd(OP_MOVE, 8'h00, 8'(ROWS - 1), 8'(COLUMNS - 1), 11'h000));
        send_cmd(mk_cmd(OP_MOVE, 8'h00, 8'(ROWS), 8'h00, 11'h000));
        send_cmd(mk_cmd(OP_MOVE, 8'h00, 8'h00, 8'(COLUMNS), 11'h000));
        send_cmd(mk_cmd(OP_MOVE, 8'h00, 8'hFF, 8'hFF, 11'h000));
        send_cmd(mk_cmd(OP_MOVE, 8'h00, 8'h00, 8'h00, 11'h000));
        drain_console();
    endtask

    // Wrap at the end of the last row, then newline on the last row
    task automatic test_wrap_and_scroll();
        send_cmd(mk_cmd(OP_MOVE, 8'h00, 8'(ROWS - 1), 8'(COLUMNS - 2), 11'h000));
        send_cmd(mk_cmd(OP_PUT, 8'h41, 8'h00, 8'h00, 11'h000));
        send_cmd(mk_cmd(OP_PUT, 8'h42, 8'h00, 8'h00, 11'h000));
        send_cmd(mk_cmd(OP_PUT, NEWLINE_CODE, 8'h00, 8'h00, 11'h000));
        send_cmd(mk_cmd(OP_READ, 8'h00, 8'h00, 8'h00, 11'(CELL_COUNT - 2 * COLUMNS - 2)));
        drain_console();
    endtask

    task automatic test_clear_screen();
        send_cmd(mk_cmd(OP_CLEAR, 8'h00, 8'h00, 8'h00, 11'h000));
        send_cmd(mk_cmd(OP_READ, 8'h00, 8'h00, 8'h00, 11'd0));
        send_cmd(mk_cmd(OP_READ, 8'h00, 8'h00, 8'h00, 11'(CELL_COUNT - 1)));
        drain_console();
    endtask

    // Attribute register at both extremes
    task automatic test_attribute_extremes();
        write_attr(8'h00);
        send_cmd(mk_cmd(OP_PUT, 8'h5A, 8'h00, 8'h00, 11'h000));
        send_cmd(mk_cmd(OP_READ, 8'h00, 8'h00, 8'h00, 11'(mirror_hw_loc - 1)));
        drain_console();
        write_attr(8'hFF);
        send_cmd(mk_cmd(OP_PUT, 8'hA5, 8'h00, 8'h00, 11'h000));
        send_cmd(mk_cmd(OP_READ, 8'h00, 8'h00, 8'h00, 11'(mirror_hw_loc - 1)));
        drain_console();
    endtask

    // Random commands, weighted toward writing text near the bottom rows
    task automatic test_random_traffic(input int n_items);
        t_cmd_item c;
        int        pick;
        repeat (n_items) begin
            c    = mk_cmd(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 11'($urandom));
            pick = $urandom_range(99);
            if (pick < 57) begin
                c.op = OP_PUT;
                pick = $urandom_range(99);
                if (pick < 12)
                    c.char_code = NEWLINE_CODE;
                else if (pick < 85)
                    c.char_code = 8'($urandom_range(126, 32));
            end else if (pick < 74) begin
                c.op = OP_MOVE;
                if ($urandom_range(99) < 80) begin
                    c.target_row = ($urandom_range(1))
                                   ? 8'($urandom_range(ROWS - 1, ROWS - 3))
                                   : 8'($urandom_range(ROWS - 1));
                    c.target_col = 8'($urandom_range(COLUMNS - 1));
                end
            end else if (pick < 97) begin
                c.op = OP_READ;
                // half the reads look at the cursor row, where text just went
                if ($urandom_range(1))
                    c.cell_index = 11'(mirror_row * COLUMNS + $urandom_range(COLUMNS - 1));
            end else begin
                c.op = OP_CLEAR;
            end
            send_cmd(c);
        end
        drain_console();
    endtask

    // Receiver stalls for a long stretch while commands keep coming
    task automatic test_backpressure();
        rsp_hold_cycles = 400;
        repeat (30)
            send_cmd(mk_cmd(OP_PUT, 8'($urandom_range(126, 32)), 8'h00, 8'h00, 11'h000));
        drain_console();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_clk             = 1'b0;
        i_rst_n           = 1'b0;
        cmd_if.valid      = 1'b0;
        cmd_if.op         = OP_PUT;
        cmd_if.char_code  = '0;
        cmd_if.target_row = '0;
        cmd_if.target_col = '0;
        cmd_if.cell_index = '0;
        cfg_if.valid      = 1'b0;
        cfg_if.data       = '0;
        mismatch_count    = 0;
        idle_pct          = 29;
        rsp_hold_cycles   = 0;
        mirror_row        = 0;
        mirror_col        = 0;
        mirror_hw_loc     = 0;
        mirror_attr       = ATTR_RESET;
        for (int i = 0; i < CELL_COUNT; i++)
            screen_mirror[i] = '0;

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_state();
        test_put_chars();
        test_cursor_moves();
        test_wrap_and_scroll();
        test_clear_screen();
        test_attribute_extremes();
        test_backpressure();

        // random phases, a new attribute for each
        repeat (4) begin
            write_attr(8'($urandom));
            test_random_traffic(220);
        end
        // long stretch with no idling on either side
        idle_pct = 0;
        write_attr(ATTR_RESET);
        test_random_traffic(180);
        idle_pct = 29;

        if (mismatch_count == 0 && pending_rsp_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
